// File: design/tnb_pkg.sv
// Shared types, constants and helper functions of the tanh neuron backprop unit.
package tnb_pkg;

  localparam int FANOUT      = 64;
  localparam int TANH_DEPTH  = 256;
  localparam int WA          = $clog2(FANOUT);
  localparam int TANH_AW     = $clog2(TANH_DEPTH);

  // Step of 2x per tanh table bin in Q0.32; bins cover the input range [0, 8).
  localparam logic [63:0] TANH_STEP = (64'd16 << 32) / 64'(TANH_DEPTH);

  typedef enum logic [2:0] {
    CMD_FWD  = 3'd0,
    CMD_TGT  = 3'd1,
    CMD_HID  = 3'd2,
    CMD_UPD  = 3'd3,
    CMD_LOAD = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_OUT    = 2'd0,
    KIND_GRAD   = 2'd1,
    KIND_WEIGHT = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_LEARN_RATE = 1'b0,
    CFG_MOMENTUM   = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_HM, ST_ACC, ST_TANH, ST_D1, ST_D2, ST_G1, ST_G2,
    ST_H1, ST_H2, ST_H3, ST_U1, ST_U2, ST_U3, ST_U4
  } state_t;

  // One classified command waiting in the queue between front and back.
  typedef struct packed {
    cmd_t               cmd;
    logic [5:0]         idx;
    logic               ok;
    logic signed [15:0] val;
    logic signed [15:0] lw;
    logic               last;
  } item_t;

  typedef logic [12:0] tanh_tab_t [TANH_DEPTH];

  // Restoring long division, used only while the table is built at elaboration.
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg_q32(logic [63:0] y);
    logic signed [63:0] sum;
    logic [63:0]        term;
    sum  = 64'sd1 <<< 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64((term * y) >> 32, 64'(k));
      if ((k & 1) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    return 64'(sum);
  endfunction

  // Entry i is tanh at the middle of bin i, in unsigned Q1.12, from an exp(-2c) recurrence.
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t   tab;
    logic [63:0] h, t, r, one, tt, num, den;
    h   = TANH_STEP;
    t   = exp_neg_q32(h >> 1);
    r   = exp_neg_q32(h);
    one = 64'd1 << 32;
    for (int i = 0; i < TANH_DEPTH; i++) begin
      tt     = (t > one) ? one : t;
      num    = (one - tt) * 64'd4096;
      den    = one + tt;
      tab[i] = 13'(udiv64(num + (den >> 1), den));
      t      = (t * r + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

  function automatic logic signed [15:0] sat16(logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// File: design/tanh_neuron_backprop_unit.sv
// Top level of the tanh neuron backprop unit: ports, configuration registers, front and back.
//
// One neuron of a tanh backpropagation network in signed Q3.12 fixed point. Commands arrive
// as stream transfers and pass through a small classifying front end into a two-entry queue,
// so the input side keeps taking transfers until the queue is full, while the execution side
// works or while a result waits in the output register. Execution is sequential, one command
// at a time, driven by a single shared multiplier with a register after it; the multiplier
// chain of each command sets its steps, and a finished result waits while the output register
// is full. Weights live in a 64-entry memory whose slots read back as undefined until loaded;
// deltas read as zero until first written. Learning rate and momentum must be written through
// the configuration channel only while the unit is idle; the block itself does not enforce
// this, and the channel is always ready.
module tanh_neuron_backprop_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[2:0], index[8:3], value[24:9], link_weight[40:25], zeros above
  input  logic [47:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot[5:0], result_value[21:6], zeros above
  output logic [23:0] out_tdata,
  // kind[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]    learn_rate_r, momentum_r;
  logic           q_valid, q_pop;
  tnb_pkg::item_t q_item;
  logic [5:0]     slot;
  logic [15:0]    result_value;

  assign cfg_ready = 1'b1;

  // Configuration registers; a transfer lands in the register its index names.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r <= 16'd9830;
      momentum_r   <= 16'd32768;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tnb_pkg::cfg_idx_t'(cfg_index))
        tnb_pkg::CFG_LEARN_RATE: learn_rate_r <= cfg_data;
        tnb_pkg::CFG_MOMENTUM:   momentum_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  tnb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tdata[2:0]),
    .in_idx   (in_tdata[8:3]),
    .in_val   (in_tdata[24:9]),
    .in_lw    (in_tdata[40:25]),
    .in_last  (in_tlast),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  tnb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .learn_rate (learn_rate_r),
    .momentum   (momentum_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_slot   (slot),
    .out_value  (result_value)
  );

  assign out_tdata = {2'b00, result_value, slot};

endmodule

// File: design/tnb_front.sv
// Input side: accepts stream transfers, drops meaningless commands, queues the rest.
module tnb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_cmd,
  input  logic [5:0]       in_idx,
  input  logic [15:0]      in_val,
  input  logic [15:0]      in_lw,
  input  logic             in_last,
  output logic             q_valid,
  input  logic             q_pop,
  output tnb_pkg::item_t   q_item
);

  tnb_pkg::item_t q_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           keep, push, slot_ok;
  tnb_pkg::item_t item;

  assign in_ready = (cnt_r != 2'd2);
  assign slot_ok  = ({26'd0, in_idx} < 32'(tnb_pkg::FANOUT));

  always_comb begin
    unique case (in_cmd)
      tnb_pkg::CMD_FWD, tnb_pkg::CMD_TGT, tnb_pkg::CMD_HID: keep = 1'b1;
      tnb_pkg::CMD_UPD, tnb_pkg::CMD_LOAD:                  keep = slot_ok;
      default:                                              keep = 1'b0;
    endcase
  end

  always_comb begin
    item.cmd  = tnb_pkg::cmd_t'(in_cmd);
    item.idx  = in_idx;
    item.ok   = slot_ok;
    item.val  = in_val;
    item.lw   = in_lw;
    item.last = in_last;
  end

  assign push    = in_valid && in_ready && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= item;
  end

endmodule

// File: design/tnb_back.sv
// Execution side: sequencer, shared multiplier, weight and delta stores, result register.
module tnb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  tnb_pkg::item_t     q_item,
  input  logic [15:0]        learn_rate,
  input  logic [15:0]        momentum,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [5:0]         out_slot,
  output logic [15:0]        out_value
);

  tnb_pkg::state_t    state_r, state_nxt;
  tnb_pkg::item_t     cur_r;
  logic signed [39:0] acc_r;
  logic signed [15:0] olev_r;
  logic signed [18:0] d_r;
  logic signed [54:0] prod_r;
  logic signed [59:0] sum_r;
  logic signed [32:0] tmp_r;
  logic signed [15:0] w_rd_r, d_raw_r;
  logic               dv_rd_r;
  logic [15:0]        wmem [tnb_pkg::FANOUT];
  logic [15:0]        dmem [tnb_pkg::FANOUT];
  logic [tnb_pkg::FANOUT-1:0] dv_r;
  logic [tnb_pkg::WA-1:0]     addr;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [5:0]         out_slot_r;
  logic [15:0]        out_val_r;

  logic               ofree, emit, w_we, load_we, upd_we;
  logic signed [33:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [15:0] delta, res, nd, w_eff;
  logic signed [40:0] acc_sum;
  logic signed [39:0] acc_sat;
  logic signed [40:0] acc_rnd;
  logic signed [15:0] x;
  logic [16:0]        m;
  logic [16+tnb_pkg::TANH_AW:0] bin_w;
  logic [tnb_pkg::TANH_AW-1:0]  bin;
  logic signed [16:0] tanh_v;
  logic signed [60:0] wide, wide_rnd;
  logic signed [55:0] sq_rnd;
  logic signed [16:0] new_w;

  assign addr  = tnb_pkg::WA'(cur_r.idx);
  assign ofree = !out_valid_r || out_ready;
  assign delta = dv_rd_r ? d_raw_r : 16'sd0;
  assign w_eff = cur_r.ok ? w_rd_r : 16'sd0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tnb_pkg::ST_IDLE:  if (q_valid) state_nxt = tnb_pkg::ST_FETCH;
      tnb_pkg::ST_FETCH: begin
        unique case (cur_r.cmd)
          tnb_pkg::CMD_FWD: state_nxt = tnb_pkg::ST_ACC;
          tnb_pkg::CMD_HID: state_nxt = tnb_pkg::ST_HM;
          tnb_pkg::CMD_TGT: state_nxt = tnb_pkg::ST_D1;
          tnb_pkg::CMD_UPD: state_nxt = tnb_pkg::ST_U1;
          default:          state_nxt = tnb_pkg::ST_IDLE;
        endcase
      end
      tnb_pkg::ST_HM:   state_nxt = tnb_pkg::ST_ACC;
      tnb_pkg::ST_ACC: begin
        if (!cur_r.last) state_nxt = tnb_pkg::ST_IDLE;
        else if (cur_r.cmd == tnb_pkg::CMD_FWD) state_nxt = tnb_pkg::ST_TANH;
        else state_nxt = tnb_pkg::ST_D1;
      end
      tnb_pkg::ST_TANH: if (ofree) state_nxt = tnb_pkg::ST_IDLE;
      tnb_pkg::ST_D1:   state_nxt = tnb_pkg::ST_D2;
      tnb_pkg::ST_D2:   state_nxt = (cur_r.cmd == tnb_pkg::CMD_TGT) ? tnb_pkg::ST_G1
                                                                     : tnb_pkg::ST_H1;
      tnb_pkg::ST_G1:   state_nxt = tnb_pkg::ST_G2;
      tnb_pkg::ST_G2:   if (ofree) state_nxt = tnb_pkg::ST_IDLE;
      tnb_pkg::ST_H1:   state_nxt = tnb_pkg::ST_H2;
      tnb_pkg::ST_H2:   state_nxt = tnb_pkg::ST_H3;
      tnb_pkg::ST_H3:   if (ofree) state_nxt = tnb_pkg::ST_IDLE;
      tnb_pkg::ST_U1:   state_nxt = tnb_pkg::ST_U2;
      tnb_pkg::ST_U2:   state_nxt = tnb_pkg::ST_U3;
      tnb_pkg::ST_U3:   state_nxt = tnb_pkg::ST_U4;
      tnb_pkg::ST_U4:   if (ofree) state_nxt = tnb_pkg::ST_IDLE;
      default:          state_nxt = tnb_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    q_pop   = 1'b0;
    emit    = 1'b0;
    load_we = 1'b0;
    upd_we  = 1'b0;
    unique case (state_r)
      tnb_pkg::ST_IDLE:  q_pop   = q_valid;
      tnb_pkg::ST_FETCH: load_we = (cur_r.cmd == tnb_pkg::CMD_LOAD);
      tnb_pkg::ST_TANH, tnb_pkg::ST_G2, tnb_pkg::ST_H3: emit = ofree;
      tnb_pkg::ST_U4: begin
        emit   = ofree;
        upd_we = ofree;
      end
      default: ;
    endcase
  end
  assign w_we = load_we || upd_we;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      tnb_pkg::ST_FETCH: begin
        mul_a = 34'(cur_r.val);
        mul_b = 21'(cur_r.lw);
      end
      tnb_pkg::ST_HM: begin
        mul_a = 34'(w_eff);
        mul_b = 21'(cur_r.val);
      end
      tnb_pkg::ST_D1: begin
        mul_a = 34'(olev_r);
        mul_b = 21'(olev_r);
      end
      tnb_pkg::ST_G1: begin
        mul_a = 34'(17'(cur_r.val) - 17'(olev_r));
        mul_b = 21'(d_r);
      end
      tnb_pkg::ST_H1: begin
        mul_a = $signed({14'd0, acc_r[19:0]});
        mul_b = 21'(d_r);
      end
      tnb_pkg::ST_H2: begin
        mul_a = 34'($signed(acc_r[39:20]));
        mul_b = 21'(d_r);
      end
      tnb_pkg::ST_U1: begin
        mul_a = $signed({18'd0, learn_rate});
        mul_b = 21'(olev_r);
      end
      tnb_pkg::ST_U2: begin
        mul_a = $signed({18'd0, momentum});
        mul_b = 21'(delta);
      end
      tnb_pkg::ST_U3: begin
        mul_a = 34'(tmp_r);
        mul_b = 21'(cur_r.val);
      end
      default: ;
    endcase
  end

  // Accumulator add with saturation to 40 bits.
  always_comb begin
    acc_sum = 41'(acc_r) + 41'($signed(prod_r[31:0]));
    if (acc_sum > 41'sh07f_ffff_ffff) acc_sat = 40'sh7f_ffff_ffff;
    else if (acc_sum < -41'sh080_0000_0000) acc_sat = 40'sh80_0000_0000;
    else acc_sat = acc_sum[39:0];
  end

  // Tanh lookup from the closed sum.
  always_comb begin
    acc_rnd = 41'(acc_r) + 41'sd2048;
    x       = tnb_pkg::sat16(64'(acc_rnd >>> 12));
    m       = x[15] ? (17'd0 - 17'(x)) : 17'(x);
    bin_w   = {m, {tnb_pkg::TANH_AW{1'b0}}} >> 15;
    bin     = (bin_w > (17 + tnb_pkg::TANH_AW)'(tnb_pkg::TANH_DEPTH - 1))
              ? tnb_pkg::TANH_AW'(tnb_pkg::TANH_DEPTH - 1) : bin_w[tnb_pkg::TANH_AW-1:0];
    tanh_v  = 17'(tnb_pkg::TANH_TAB[bin]);
  end

  // Final rounding for gradients and the update, and result selection including the tanh output.
  always_comb begin
    sq_rnd = 56'(prod_r) + 56'sd2048;
    wide   = '0;
    case (state_r)
      tnb_pkg::ST_G2: wide = 61'(prod_r) + 61'sd2048;
      tnb_pkg::ST_H3: wide = 61'(sum_r) + (61'(prod_r) <<< 20) + (61'sd1 <<< 23);
      default:        wide = 61'(sum_r) + 61'(prod_r) + (61'sd1 <<< 39);
    endcase
    wide_rnd = wide;
    nd    = tnb_pkg::sat16(64'(wide_rnd >>> 40));
    new_w = 17'(w_rd_r) + 17'(nd);
    unique case (state_r)
      tnb_pkg::ST_TANH: res = x[15] ? 16'(-tanh_v) : 16'(tanh_v);
      tnb_pkg::ST_G2:   res = tnb_pkg::sat16(64'(wide_rnd >>> 12));
      tnb_pkg::ST_H3:   res = tnb_pkg::sat16(64'(wide_rnd >>> 24));
      default:          res = tnb_pkg::sat16(64'(new_w));
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tnb_pkg::ST_IDLE;
      acc_r       <= '0;
      olev_r      <= '0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tnb_pkg::ST_ACC) acc_r <= acc_sat;
      if (emit && (state_r == tnb_pkg::ST_TANH || state_r == tnb_pkg::ST_H3)) acc_r <= '0;
      if (emit && state_r == tnb_pkg::ST_TANH) olev_r <= res;
      if (w_we) dv_r[addr] <= 1'b1;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
    // The last product is held while a finished result waits for the output register.
    if (state_r != tnb_pkg::ST_G2 && state_r != tnb_pkg::ST_H3 && state_r != tnb_pkg::ST_U4)
      prod_r <= 55'(mul_a * mul_b);
    if (state_r == tnb_pkg::ST_D2) begin
      d_r <= 19'sd4096 - 19'(sq_rnd >>> 12);
    end
    if (state_r == tnb_pkg::ST_H2) sum_r <= 60'(prod_r);
    if (state_r == tnb_pkg::ST_U2) tmp_r <= prod_r[32:0];
    if (state_r == tnb_pkg::ST_U3) sum_r <= 60'(prod_r) <<< 12;
    if (emit) begin
      out_val_r  <= res;
      out_kind_r <= (state_r == tnb_pkg::ST_TANH) ? tnb_pkg::KIND_OUT :
                    (state_r == tnb_pkg::ST_U4)   ? tnb_pkg::KIND_WEIGHT : tnb_pkg::KIND_GRAD;
      out_slot_r <= (state_r == tnb_pkg::ST_U4) ? cur_r.idx : 6'd0;
    end
  end

  // Weight and delta stores, one write and one registered read each.
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[addr] <= load_we ? cur_r.val : res;
      dmem[addr] <= load_we ? 16'd0 : nd;
    end
    w_rd_r  <= wmem[addr];
    d_raw_r <= dmem[addr];
    dv_rd_r <= dv_r[addr];
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_slot  = out_slot_r;
  assign out_value = out_val_r;

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && state_r == tnb_pkg::ST_TANH) |=> (acc_r == 40'sd0))
    else $error("accumulator not cleared after output value");
  a_deriv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tnb_pkg::ST_D2) |=> (d_r <= 19'sd4096))
    else $error("tanh derivative above one");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !emit)
    else $error("result register overwritten while held");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == tnb_pkg::ST_FETCH))
    else $error("queue popped outside idle");

endmodule
